>>> sv/addressed_frame_receiver_macros.svh
// Assertion macros shared by the RTL.
`ifndef ADDRESSED_FRAME_RECEIVER_MACROS_SVH
`define ADDRESSED_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define AFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver check failed");
// The consequent must hold in the cycle after the antecedent.
`define AFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver check failed");
`else
`define AFR_ASSERT_SAME(label, clk, rst, ante, cons)
`define AFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/afr_pkg.sv
package afr_pkg;

   localparam int BYTE_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int CSR_INDEX_W = 2;

   localparam int MAX_PAYLOAD_DEFAULT = 32;

   localparam logic [BYTE_W-1:0] OWN_ADDRESS_RESET     = 8'd1;
   localparam logic [BYTE_W-1:0] EXPECTED_ORIGIN_RESET = 8'd0;
   localparam logic [BYTE_W-1:0] START_BYTE_RESET      = 8'd126;
   localparam logic [BYTE_W-1:0] CHECK_BASE            = 8'hFF;
   localparam logic [BYTE_W-1:0] BROADCAST_ADDRESS     = 8'd0;
   localparam logic [BYTE_W-1:0] ANY_ORIGIN            = 8'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OWN_ADDRESS     = 2'd0,
      CSR_EXPECTED_ORIGIN = 2'd1,
      CSR_START_BYTE      = 2'd2
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPTED   = 3'd0,
      ST_TOO_LONG   = 3'd1,
      ST_CHECKSUM   = 3'd2,
      ST_WRONG_DEST = 3'd3,
      ST_WRONG_ORIG = 3'd4
   } status_type;

   // Controller to datapath.
   typedef struct packed {
      logic take_origin;
      logic take_dest;
      logic take_len;
      logic take_data;
      logic take_check;
      logic rd_en;
      logic idx_inc;
      logic show_data;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic start_hit;
      logic len_zero;
      logic data_done;
      logic frame_single;
      logic last_row;
   } stat_type;

endpackage

>>> sv/afr_req_if.sv
interface afr_req_if;
   logic                        valid;
   logic                        ready;
   logic [afr_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

>>> sv/afr_rsp_if.sv
interface afr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [afr_pkg::STATUS_W-1:0]  status;
   logic [afr_pkg::BYTE_W-1:0]    sender;
   logic [afr_pkg::BYTE_W-1:0]    payload_length;
   logic [afr_pkg::BYTE_W-1:0]    data_byte;
   logic                          data_valid;
   logic                          last;

   modport source (output valid, output status, output sender, output payload_length,
                   output data_byte, output data_valid, output last, input ready);
   modport sink (input valid, input status, input sender, input payload_length,
                 input data_byte, input data_valid, input last, output ready);
endinterface

>>> sv/afr_ram.sv
module afr_ram #(
   parameter int WIDTH = afr_pkg::BYTE_W,
   parameter int DEPTH = afr_pkg::MAX_PAYLOAD_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/afr_ctrl.sv
module afr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  afr_pkg::stat_type stat,
   output afr_pkg::cmd_type  cmd
);
   import afr_pkg::*;

   typedef enum logic [8:0] {
      S_HUNT   = 9'b000000001,
      S_ORIGIN = 9'b000000010,
      S_DEST   = 9'b000000100,
      S_LEN    = 9'b000001000,
      S_DATA   = 9'b000010000,
      S_CHECK  = 9'b000100000,
      S_SINGLE = 9'b001000000,
      S_READ   = 9'b010000000,
      S_SHOW   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_fire;

   assign req_ready = (state_ff == S_HUNT) || (state_ff == S_ORIGIN) ||
                      (state_ff == S_DEST) || (state_ff == S_LEN) ||
                      (state_ff == S_DATA) || (state_ff == S_CHECK);
   assign rsp_valid = (state_ff == S_SINGLE) || (state_ff == S_SHOW);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_HUNT: begin
            if (req_fire && stat.start_hit) begin
               state_in = S_ORIGIN;
            end
         end
         S_ORIGIN: begin
            if (req_fire) begin
               state_in = S_DEST;
            end
         end
         S_DEST: begin
            if (req_fire) begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            if (req_fire) begin
               state_in = stat.len_zero ? S_CHECK : S_DATA;
            end
         end
         S_DATA: begin
            if (req_fire && stat.data_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (req_fire) begin
               state_in = stat.frame_single ? S_SINGLE : S_READ;
            end
         end
         S_SINGLE: begin
            if (rsp_ready) begin
               state_in = S_HUNT;
            end
         end
         S_READ: begin
            state_in = S_SHOW;
         end
         S_SHOW: begin
            if (rsp_ready) begin
               state_in = stat.last_row ? S_HUNT : S_READ;
            end
         end
         default: begin
            state_in = S_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd             = '0;
      cmd.take_origin = req_fire && (state_ff == S_ORIGIN);
      cmd.take_dest   = req_fire && (state_ff == S_DEST);
      cmd.take_len    = req_fire && (state_ff == S_LEN);
      cmd.take_data   = req_fire && (state_ff == S_DATA);
      cmd.take_check  = req_fire && (state_ff == S_CHECK);
      cmd.rd_en       = (state_ff == S_READ);
      cmd.idx_inc     = (state_ff == S_SHOW) && rsp_ready && !stat.last_row;
      cmd.show_data   = (state_ff == S_SHOW);
   end

endmodule

>>> sv/afr_dp.sv
module afr_dp #(
   parameter int MAX_PAYLOAD = afr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [afr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [afr_pkg::BYTE_W-1:0]     csr_wdata,
   input  logic [afr_pkg::BYTE_W-1:0]     rx_byte,
   input  afr_pkg::cmd_type               cmd,
   output afr_pkg::stat_type              stat,
   output logic [afr_pkg::STATUS_W-1:0]   status,
   output logic [afr_pkg::BYTE_W-1:0]     sender,
   output logic [afr_pkg::BYTE_W-1:0]     payload_length,
   output logic [afr_pkg::BYTE_W-1:0]     data_byte,
   output logic                           data_valid,
   output logic                           last
);
   import afr_pkg::*;

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int IDX_W  = $clog2(MAX_PAYLOAD + 1);
   localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

   logic [BYTE_W-1:0] own_ff, own_in;
   logic [BYTE_W-1:0] exp_ff, exp_in;
   logic [BYTE_W-1:0] start_ff, start_in;
   logic [BYTE_W-1:0] origin_ff, origin_in;
   logic [BYTE_W-1:0] dest_ff, dest_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   status_type        status_ff, status_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic [BYTE_W-1:0] count_next;
   logic [BYTE_W-1:0] want;
   status_type        verdict;
   logic              ram_we;
   logic [BYTE_W-1:0] ram_rdata;

   // Configuration registers.
   always_comb begin
      own_in   = own_ff;
      exp_in   = exp_ff;
      start_in = start_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OWN_ADDRESS:     own_in   = csr_wdata;
            CSR_EXPECTED_ORIGIN: exp_in   = csr_wdata;
            CSR_START_BYTE:      start_in = csr_wdata;
            default: begin
               own_in = own_ff;
            end
         endcase
      end
   end

   assign count_next = count_ff + 8'd1;
   assign want       = CHECK_BASE - sum_ff;

   // Frame verdict for the checksum byte now on the input.
   always_comb begin
      if (len_ff > MAX_LEN) begin
         verdict = ST_TOO_LONG;
      end else if (rx_byte != want) begin
         verdict = ST_CHECKSUM;
      end else if (dest_ff != BROADCAST_ADDRESS && dest_ff != own_ff) begin
         verdict = ST_WRONG_DEST;
      end else if (exp_ff != ANY_ORIGIN && origin_ff != exp_ff) begin
         verdict = ST_WRONG_ORIG;
      end else begin
         verdict = ST_ACCEPTED;
      end
   end

   always_comb begin
      origin_in = cmd.take_origin ? rx_byte : origin_ff;
      dest_in   = cmd.take_dest ? rx_byte : dest_ff;
      len_in    = cmd.take_len ? rx_byte : len_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      if (cmd.take_len) begin
         count_in = '0;
         sum_in   = '0;
      end else if (cmd.take_data) begin
         count_in = count_next;
         sum_in   = sum_ff + rx_byte;
      end
      status_in = cmd.take_check ? verdict : status_ff;
      idx_in    = idx_ff;
      if (cmd.take_check) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff    <= OWN_ADDRESS_RESET;
         exp_ff    <= EXPECTED_ORIGIN_RESET;
         start_ff  <= START_BYTE_RESET;
         origin_ff <= '0;
         dest_ff   <= '0;
         len_ff    <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         status_ff <= ST_ACCEPTED;
         idx_ff    <= '0;
      end else begin
         own_ff    <= own_in;
         exp_ff    <= exp_in;
         start_ff  <= start_in;
         origin_ff <= origin_in;
         dest_ff   <= dest_in;
         len_ff    <= len_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         status_ff <= status_in;
         idx_ff    <= idx_in;
      end
   end

   // Payload bytes of an oversized frame are counted but never stored.
   assign ram_we = cmd.take_data && (len_ff <= MAX_LEN) && (count_ff < MAX_LEN);

   afr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[ADDR_W-1:0]),
      .wdata (rx_byte),
      .re    (cmd.rd_en),
      .raddr (idx_ff[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      stat              = '0;
      stat.start_hit    = (rx_byte == start_ff);
      stat.len_zero     = (rx_byte == '0);
      stat.data_done    = (count_next >= len_ff);
      stat.frame_single = (verdict != ST_ACCEPTED) || (len_ff == '0);
      stat.last_row     = ((BYTE_W'(idx_ff) + 8'd1) == len_ff);
   end

   assign status         = status_ff;
   assign sender         = origin_ff;
   assign payload_length = len_ff;
   assign data_byte      = cmd.show_data ? ram_rdata : '0;
   assign data_valid     = cmd.show_data;
   assign last           = cmd.show_data ? stat.last_row : 1'b1;

endmodule

>>> sv/addressed_frame_receiver.sv
// Addressed frame receiver.
// req_bus carries received bytes, one per transfer. Between frames bytes are
// dropped until the start byte arrives; then origin, destination, length,
// the payload bytes and a checksum byte follow.
// rsp_bus carries the results of a frame once its checksum byte is taken.
// A rejected or empty frame gives one result in the cycle after the checksum
// byte. An accepted frame gives one result per payload byte; each is read
// from the payload memory in the read state and then shown in the show
// state. While bytes are being received the block takes one byte per cycle;
// while results are being delivered no byte is taken. When the receiver
// holds rsp_bus.ready low, the current result is held stable and the block
// waits. Configuration is written through csr_*; the user must write it
// only while the block is idle, as the block does not enforce this.
// Reset returns the block to hunting for the start byte and loads the
// configuration defaults; the payload memory is not cleared, since only
// bytes written in the current frame are ever read back.
module addressed_frame_receiver #(
   parameter int MAX_PAYLOAD = afr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   afr_req_if.sink                        req_bus,
   afr_rsp_if.source                      rsp_bus,
   input logic                            csr_we,
   input logic [afr_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [afr_pkg::BYTE_W-1:0]      csr_wdata
);
   import afr_pkg::*;

`include "addressed_frame_receiver_macros.svh"

   cmd_type  cmd;
   stat_type stat;
   logic     rsp_fire;

   afr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   afr_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rx_byte        (req_bus.rx_byte),
      .cmd            (cmd),
      .stat           (stat),
      .status         (rsp_bus.status),
      .sender         (rsp_bus.sender),
      .payload_length (rsp_bus.payload_length),
      .data_byte      (rsp_bus.data_byte),
      .data_valid     (rsp_bus.data_valid),
      .last           (rsp_bus.last)
   );

   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   `AFR_ASSERT_SAME(a_no_overlap, clock, reset, rsp_bus.valid, !req_bus.ready)
   `AFR_ASSERT_SAME(a_data_ok, clock, reset, rsp_bus.data_valid, rsp_bus.status == ST_ACCEPTED)
   `AFR_ASSERT_SAME(a_single_last, clock, reset, rsp_bus.valid && !rsp_bus.data_valid, rsp_bus.last)
   `AFR_ASSERT_NEXT(a_hunt_next, clock, reset, rsp_fire && rsp_bus.last, req_bus.ready && !rsp_bus.valid)

endmodule

>>> tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import afr_pkg::*;

   localparam int MAX_BODY = MAX_PAYLOAD_DEFAULT;

   typedef logic [BYTE_W-1:0] byte_list_type[$];

   typedef enum logic [2:0] {
      RX_HUNT, RX_ORIGIN, RX_DEST, RX_LEN, RX_DATA, RX_CHECK
   } rx_phase_type;

   typedef struct {
      status_type        status;
      logic [BYTE_W-1:0] sender;
      logic [BYTE_W-1:0] payload_length;
      logic [BYTE_W-1:0] data_byte;
      logic              data_valid;
      logic              last;
   } frame_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   csr_index_type csr_index;
   logic [BYTE_W-1:0] csr_wdata;

   afr_req_if req ();
   afr_rsp_if rsp ();

   addressed_frame_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req),
      .rsp_bus   (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies that the frame predictor works with.
   logic [BYTE_W-1:0] own_address_cfg     = OWN_ADDRESS_RESET;
   logic [BYTE_W-1:0] expected_origin_cfg = EXPECTED_ORIGIN_RESET;
   logic [BYTE_W-1:0] start_byte_cfg      = START_BYTE_RESET;

   rx_phase_type      rx_phase = RX_HUNT;
   logic [BYTE_W-1:0] hdr_origin;
   logic [BYTE_W-1:0] hdr_dest;
   logic [BYTE_W-1:0] hdr_length;
   logic [BYTE_W-1:0] body_count;
   logic [BYTE_W-1:0] body_sum;
   logic [BYTE_W-1:0] body_copy [MAX_BODY];

   frame_row_type     expected_rows[$];
   logic [BYTE_W-1:0] byte_queue[$];
   int                error_count = 0;
   int                frame_items = 0;

   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   bit req_took    = 1'b0;
   bit rsp_took    = 1'b0;
   int req_gap     = 0;
   int rsp_wait    = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_gap(input bit on);
      return on ? $urandom_range(0, 17) : 0;
   endfunction

   function void note_failure(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s", $realtime, msg);
   endfunction

   // Advances the frame predictor by one received byte and queues the rows
   // that a checksum byte produces.
   function void absorb_byte(input logic [BYTE_W-1:0] b);
      status_type        verdict;
      frame_row_type     row;
      logic [BYTE_W-1:0] want;
      case (rx_phase)
         RX_ORIGIN: begin
            hdr_origin = b;
            rx_phase = RX_DEST;
         end
         RX_DEST: begin
            hdr_dest = b;
            rx_phase = RX_LEN;
         end
         RX_LEN: begin
            hdr_length = b;
            body_count = '0;
            body_sum = '0;
            rx_phase = (b == 0) ? RX_CHECK : RX_DATA;
         end
         RX_DATA: begin
            if (int'(hdr_length) <= MAX_BODY && int'(body_count) < MAX_BODY)
               body_copy[body_count] = b;
            body_sum = body_sum + b;
            body_count = body_count + 1'b1;
            if (body_count >= hdr_length)
               rx_phase = RX_CHECK;
         end
         RX_CHECK: begin
            want = CHECK_BASE - body_sum;
            if (int'(hdr_length) > MAX_BODY)
               verdict = ST_TOO_LONG;
            else if (b != want)
               verdict = ST_CHECKSUM;
            else if (hdr_dest != BROADCAST_ADDRESS && hdr_dest != own_address_cfg)
               verdict = ST_WRONG_DEST;
            else if (expected_origin_cfg != ANY_ORIGIN && hdr_origin != expected_origin_cfg)
               verdict = ST_WRONG_ORIG;
            else
               verdict = ST_ACCEPTED;
            rx_phase = RX_HUNT;
            row.status = verdict;
            row.sender = hdr_origin;
            row.payload_length = hdr_length;
            if (verdict != ST_ACCEPTED || hdr_length == 0) begin
               row.data_byte = '0;
               row.data_valid = 1'b0;
               row.last = 1'b1;
               expected_rows.push_back(row);
            end else begin
               for (int k = 0; k < int'(hdr_length); k++) begin
                  row.data_byte = body_copy[k];
                  row.data_valid = 1'b1;
                  row.last = (k == int'(hdr_length) - 1);
                  expected_rows.push_back(row);
               end
            end
         end
         default: begin
            rx_phase = (b == start_byte_cfg) ? RX_ORIGIN : RX_HUNT;
         end
      endcase
   endfunction

   always @(posedge clock) begin : result_watch
      frame_row_type want;
      if (reset) begin
         req_took = 1'b0;
         rsp_took = 1'b0;
      end else begin
         req_took = req.valid && req.ready;
         rsp_took = rsp.valid && rsp.ready;
         if (rsp_took) begin
            if (expected_rows.size() == 0) begin
               note_failure($sformatf("result with none expected: status %0d data %0d",
                                      rsp.status, rsp.data_byte));
            end else begin
               want = expected_rows.pop_front();
               if (rsp.status !== want.status || rsp.sender !== want.sender ||
                   rsp.payload_length !== want.payload_length ||
                   rsp.data_byte !== want.data_byte ||
                   rsp.data_valid !== want.data_valid || rsp.last !== want.last)
                  note_failure($sformatf({
                     "mismatch: exp st %0d snd %0d len %0d dat %0d dv %0d last %0d, ",
                     "got st %0d snd %0d len %0d dat %0d dv %0d last %0d"},
                     want.status, want.sender, want.payload_length, want.data_byte,
                     want.data_valid, want.last, rsp.status, rsp.sender,
                     rsp.payload_length, rsp.data_byte, rsp.data_valid, rsp.last));
            end
         end
         if (req_took)
            absorb_byte(req.rx_byte);
      end
   end

   // Byte driver: holds an offered byte until its transfer, then waits out
   // the drawn gap before offering the next one.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req_gap = 0;
      end else if (!req.valid || req_took) begin
         if (req_gap > 0) begin
            req_gap--;
            req.valid <= 1'b0;
         end else if (byte_queue.size() != 0) begin
            req.rx_byte <= byte_queue.pop_front();
            req.valid <= 1'b1;
            req_gap = draw_gap(req_idle_on);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_took)
            rsp_wait = draw_gap(rsp_idle_on);
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   function automatic byte_list_type random_body(input int n);
      byte_list_type q;
      for (int k = 0; k < n; k++)
         q.push_back(BYTE_W'($urandom));
      return q;
   endfunction

   // Queues one frame; cut drops that many bytes from its end.
   task automatic send_frame(input logic [BYTE_W-1:0] origin, input logic [BYTE_W-1:0] dest,
                             input byte_list_type body, input bit bad_check, input int cut);
      byte_list_type     bytes;
      logic [BYTE_W-1:0] sum;
      sum = '0;
      bytes.push_back(start_byte_cfg);
      bytes.push_back(origin);
      bytes.push_back(dest);
      bytes.push_back(BYTE_W'(body.size()));
      foreach (body[k]) begin
         bytes.push_back(body[k]);
         sum = sum + body[k];
      end
      if (bad_check)
         bytes.push_back((CHECK_BASE - sum) ^ BYTE_W'($urandom_range(1, 255)));
      else
         bytes.push_back(CHECK_BASE - sum);
      repeat (cut)
         void'(bytes.pop_back());
      foreach (bytes[k])
         byte_queue.push_back(bytes[k]);
      frame_items += bytes.size();
   endtask

   task automatic send_noise(input int n);
      logic [BYTE_W-1:0] v;
      repeat (n) begin
         v = BYTE_W'($urandom);
         if (v == start_byte_cfg)
            v = v ^ 8'h01;
         byte_queue.push_back(v);
      end
   endtask

   task automatic send_random_frame();
      int                r;
      int                n;
      logic [BYTE_W-1:0] origin;
      logic [BYTE_W-1:0] dest;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         send_noise($urandom_range(1, 3));
         return;
      end
      origin = ($urandom_range(0, 9) < 7 && expected_origin_cfg != ANY_ORIGIN) ?
               expected_origin_cfg : BYTE_W'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: dest = own_address_cfg;
         4, 5:       dest = BROADCAST_ADDRESS;
         default:    dest = BYTE_W'($urandom);
      endcase
      r = $urandom_range(0, 99);
      if (r < 50)
         n = $urandom_range(0, 4);
      else if (r < 80)
         n = $urandom_range(5, 12);
      else if (r < 92)
         n = $urandom_range(13, MAX_BODY);
      else if (r < 96)
         n = MAX_BODY;
      else
         n = $urandom_range(MAX_BODY + 1, MAX_BODY + 8);
      // A truncated frame lets the next start byte land inside the old frame.
      send_frame(origin, dest, random_body(n), $urandom_range(0, 99) < 12,
                 ($urandom_range(0, 99) < 6) ? $urandom_range(1, 3) : 0);
   endtask

   task automatic wait_idle();
      while (byte_queue.size() != 0 || req.valid || expected_rows.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Drains the block and feeds zero bytes until the predictor is hunting
   // again, so that registers change only between frames.
   task automatic close_phase();
      wait_idle();
      while (rx_phase != RX_HUNT) begin
         byte_queue.push_back(8'h00);
         wait_idle();
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_OWN_ADDRESS:     own_address_cfg = value;
         CSR_EXPECTED_ORIGIN: expected_origin_cfg = value;
         default:             start_byte_cfg = value;
      endcase
   endtask

   task automatic configure(input logic [BYTE_W-1:0] own, input logic [BYTE_W-1:0] origin,
                            input logic [BYTE_W-1:0] start);
      write_reg(CSR_OWN_ADDRESS, own);
      write_reg(CSR_EXPECTED_ORIGIN, origin);
      write_reg(CSR_START_BYTE, start);
      req_idle_on = ($urandom_range(0, 3) != 0);
      rsp_idle_on = ($urandom_range(0, 3) != 0);
   endtask

   initial begin
      byte_list_type     body;
      logic [BYTE_W-1:0] own_set    [5];
      logic [BYTE_W-1:0] origin_set [5];
      logic [BYTE_W-1:0] start_set  [5];
      req.valid = 1'b0;
      req.rx_byte = '0;
      rsp.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_OWN_ADDRESS;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset register values: own address 1, any origin, start byte 126.
      send_noise(1);
      byte_queue.push_back(8'h00);
      byte_queue.push_back(8'hFF);
      body = {8'hA5};
      send_frame(8'h05, 8'h01, body, 1'b0, 0);
      body.delete();
      send_frame(8'hFF, BROADCAST_ADDRESS, body, 1'b0, 0);
      body.delete();
      for (int k = 0; k < MAX_BODY; k++)
         body.push_back((k % 2 == 0) ? 8'hFF : 8'h00);
      body[1] = START_BYTE_RESET;
      send_frame(8'h00, 8'h01, body, 1'b0, 0);
      body = {8'h01, 8'h02};
      send_frame(8'h10, 8'h01, body, 1'b1, 0);
      body = {START_BYTE_RESET};
      send_frame(8'h10, 8'h02, body, 1'b0, 0);
      // Too long wins over a bad checksum and a foreign destination.
      send_frame(8'h10, 8'h02, random_body(MAX_BODY + 1), 1'b1, 0);
      body = {8'h33};
      send_frame(8'h10, 8'h02, body, 1'b1, 0);
      close_phase();

      configure(8'hFF, 8'hFF, 8'h00);
      body = {8'h11};
      send_frame(8'h01, 8'hFF, body, 1'b0, 0);
      body = {8'h00, 8'hFF};
      send_frame(8'hFF, 8'hFF, body, 1'b0, 0);
      body.delete();
      send_frame(8'h01, BROADCAST_ADDRESS, body, 1'b0, 0);
      body = {8'h44};
      send_frame(8'h01, 8'h03, body, 1'b0, 0);
      close_phase();

      own_set    = '{8'h00, 8'hFF, 8'h5A, BYTE_W'($urandom), 8'h80};
      origin_set = '{8'h00, 8'h00, 8'h33, BYTE_W'($urandom), 8'hFF};
      start_set  = '{8'hFF, 8'h7E, 8'h00, BYTE_W'($urandom), 8'h80};
      for (int p = 0; p < 5; p++) begin
         configure(own_set[p], origin_set[p], start_set[p]);
         frame_items = 0;
         while (frame_items < 10)
            send_random_frame();
         close_phase();
      end

      wait_idle();
      if (error_count == 0 && expected_rows.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
